// ----- rtl/rqe_pkg.sv -----
// Package for the retransmit queue engine: operation and result codes,
// the table entry and result word types. No dependencies.
package rqe_pkg;

   localparam int QUEUE_DEPTH_DEF = 32;

   localparam logic [2:0] OP_ADD     = 3'd0;
   localparam logic [2:0] OP_EXISTS  = 3'd1;
   localparam logic [2:0] OP_CONFIRM = 3'd2;
   localparam logic [2:0] OP_PROCESS = 3'd3;
   localparam logic [2:0] OP_CLEAR   = 3'd4;

   localparam logic [2:0] KIND_ADD      = 3'd0;
   localparam logic [2:0] KIND_EXISTS   = 3'd1;
   localparam logic [2:0] KIND_CONFIRM  = 3'd2;
   localparam logic [2:0] KIND_RELEASED = 3'd3;
   localparam logic [2:0] KIND_RESEND   = 3'd4;
   localparam logic [2:0] KIND_DONE     = 3'd5;

   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_RETRY_LIMIT    = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RETRY_INTERVAL = 1'd1;

   localparam logic [7:0]  RETRY_LIMIT_RST    = 8'd5;
   localparam logic [31:0] RETRY_INTERVAL_RST = 32'd1000;
   localparam logic [7:0]  RETRIES_MAX        = 8'hFF;

   typedef struct packed {
      logic [31:0] stamp;
      logic [31:0] dest_addr;
      logic [15:0] dest_port;
      logic [15:0] size;
      logic [31:0] handle;
      logic [31:0] sent_at;
      logic [7:0]  retries;
   } entry_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic        ok;
      logic [4:0]  slot;
      logic [31:0] out_stamp;
      logic [31:0] out_dest_addr;
      logic [15:0] out_dest_port;
      logic [15:0] out_frame_size;
      logic [31:0] out_frame_handle;
      logic [7:0]  out_retries;
      logic        last;
   } rsp_type;

endpackage

// ----- rtl/rqe_req_if.sv -----
// Request channel of the retransmit queue engine: one operation word.
// Depends on nothing.
interface rqe_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  op;
   logic [31:0] stamp;
   logic [31:0] dest_addr;
   logic [15:0] dest_port;
   logic [15:0] frame_size;
   logic [31:0] frame_handle;
   logic [31:0] now;

   modport source (output valid, op, stamp, dest_addr, dest_port, frame_size,
                   frame_handle, now, input ready);
   modport sink (input valid, op, stamp, dest_addr, dest_port, frame_size,
                 frame_handle, now, output ready);
endinterface

// ----- rtl/rqe_rsp_if.sv -----
// Response channel of the retransmit queue engine: one result word.
// Depends on nothing.
interface rqe_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic        ok;
   logic [4:0]  slot;
   logic [31:0] out_stamp;
   logic [31:0] out_dest_addr;
   logic [15:0] out_dest_port;
   logic [15:0] out_frame_size;
   logic [31:0] out_frame_handle;
   logic [7:0]  out_retries;
   logic        last;

   modport source (output valid, kind, ok, slot, out_stamp, out_dest_addr,
                   out_dest_port, out_frame_size, out_frame_handle, out_retries,
                   last, input ready);
   modport sink (input valid, kind, ok, slot, out_stamp, out_dest_addr,
                 out_dest_port, out_frame_size, out_frame_handle, out_retries,
                 last, output ready);
endinterface

// ----- rtl/rqe_csr_if.sv -----
// Register write channel of the retransmit queue engine.
// Depends on nothing.
interface rqe_csr_if;
   logic        valid;
   logic        ready;
   logic [0:0]  index;
   logic [31:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/retransmit_queue_engine.sv -----
// Retransmit queue engine top level: sequencer around one entry table memory.
// Depends on rqe_pkg and the rqe_req_if, rqe_rsp_if and rqe_csr_if interfaces.
//
// Usage: each request word on req carries one operation (add, exists, confirm,
// process, clear). Its results leave on rsp as one or more words, the final one
// flagged by last. Register writes on csr (retry limit, retry interval) are
// always taken and must only happen while the engine is idle.
// The table lives in a one-port-read, one-port-write memory with registered
// read data; every table entry visited takes a read step, then an act step.
// Process walks the table twice, first for drops and then for resends.
// Requests are taken one at a time: req.ready is high only between operations.
// A result waits in a pending register and an output register; when rsp is
// stalled, the walk through the table simply pauses.
// Reset empties the table at once (count to zero, no clearing pass) and loads
// the register defaults: retry limit 5, retry interval 1000.
module retransmit_queue_engine #(
   parameter int QUEUE_DEPTH = rqe_pkg::QUEUE_DEPTH_DEF
) (
   input  logic      clock,
   input  logic      reset,
   rqe_req_if.sink   req,
   rqe_rsp_if.source rsp,
   rqe_csr_if.sink   csr
);
   import rqe_pkg::*;

   localparam int IW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [13:0] {
      ST_IDLE    = 14'b00000000000001,
      ST_ADD     = 14'b00000000000010,
      ST_SRCH_RD = 14'b00000000000100,
      ST_SRCH_EX = 14'b00000000001000,
      ST_SHFT_RD = 14'b00000000010000,
      ST_SHFT_EX = 14'b00000000100000,
      ST_CONF    = 14'b00000001000000,
      ST_DROP_RD = 14'b00000010000000,
      ST_DROP_EX = 14'b00000100000000,
      ST_SEND_RD = 14'b00001000000000,
      ST_SEND_EX = 14'b00010000000000,
      ST_CLR_RD  = 14'b00100000000000,
      ST_CLR_EX  = 14'b01000000000000,
      ST_FIN     = 14'b10000000000000
   } state_type;

   entry_type entry_mem [QUEUE_DEPTH];
   entry_type rd_data_ff;

   state_type state_ff, state_in;
   logic [2:0]    op_ff, op_in;
   entry_type     new_ff, new_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] keep_ff, keep_in;
   logic [CW-1:0] count_ff, count_in;
   logic [IW-1:0] pos_ff, pos_in;
   logic [7:0]    limit_ff, limit_in;
   logic [31:0]   interval_ff, interval_in;
   logic          pend_valid_ff, pend_valid_in;
   rsp_type       pend_ff, pend_in;
   logic          out_valid_ff, out_valid_in;
   rsp_type       out_ff, out_in;

   logic          mem_we, mem_re;
   logic [IW-1:0] mem_waddr;
   entry_type     mem_wdata;
   logic          emit, emit_ok, out_free;
   rsp_type       item;
   entry_type     upd;
   logic [CW-1:0] idx_dec;
   logic [31:0]   age;

   assign req.ready = (state_ff == ST_IDLE);
   assign csr.ready = 1'b1;
   assign out_free  = !out_valid_ff || rsp.ready;
   assign emit_ok   = !pend_valid_ff || out_free;
   assign idx_dec   = idx_ff - CW'(1);
   assign age       = new_ff.sent_at - rd_data_ff.sent_at;

   always_comb begin
      upd = rd_data_ff;
      upd.sent_at = new_ff.sent_at;
      if (rd_data_ff.retries != RETRIES_MAX) begin
         upd.retries = rd_data_ff.retries + 8'd1;
      end
   end

   always_comb begin
      state_in = state_ff;
      op_in = op_ff;
      new_in = new_ff;
      idx_in = idx_ff;
      keep_in = keep_ff;
      count_in = count_ff;
      pos_in = pos_ff;
      limit_in = limit_ff;
      interval_in = interval_ff;
      pend_valid_in = pend_valid_ff;
      pend_in = pend_ff;
      out_valid_in = out_valid_ff;
      out_in = out_ff;
      mem_we = 1'b0;
      mem_re = 1'b0;
      mem_waddr = idx_ff[IW-1:0];
      mem_wdata = rd_data_ff;
      emit = 1'b0;
      item = '0;

      if (out_valid_ff && rsp.ready) begin
         out_valid_in = 1'b0;
      end

      if (csr.valid) begin
         case (csr.index)
            CSR_RETRY_LIMIT: limit_in = csr.data[7:0];
            CSR_RETRY_INTERVAL: interval_in = csr.data;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               op_in = req.op;
               new_in.stamp = req.stamp;
               new_in.dest_addr = req.dest_addr;
               new_in.dest_port = req.dest_port;
               new_in.size = req.frame_size;
               new_in.handle = req.frame_handle;
               new_in.sent_at = req.now;
               new_in.retries = '0;
               idx_in = '0;
               keep_in = '0;
               case (req.op)
                  OP_ADD: state_in = ST_ADD;
                  OP_EXISTS, OP_CONFIRM: state_in = ST_SRCH_RD;
                  OP_PROCESS: state_in = ST_DROP_RD;
                  OP_CLEAR: state_in = ST_CLR_RD;
                  default: state_in = ST_FIN;
               endcase
            end
         end
         ST_ADD: begin
            emit = 1'b1;
            item.kind = KIND_ADD;
            if (count_ff != CW'(QUEUE_DEPTH)) begin
               item.ok = 1'b1;
               item.slot = 5'(count_ff);
            end
            if (emit_ok) begin
               if (count_ff != CW'(QUEUE_DEPTH)) begin
                  mem_we = 1'b1;
                  mem_waddr = count_ff[IW-1:0];
                  mem_wdata = new_ff;
                  count_in = count_ff + CW'(1);
               end
               state_in = ST_FIN;
            end
         end
         ST_SRCH_RD: begin
            if (idx_ff == count_ff) begin
               emit = 1'b1;
               item.kind = (op_ff == OP_EXISTS) ? KIND_EXISTS : KIND_CONFIRM;
               if (emit_ok) begin
                  state_in = ST_FIN;
               end
            end else begin
               mem_re = 1'b1;
               state_in = ST_SRCH_EX;
            end
         end
         ST_SRCH_EX: begin
            if (rd_data_ff.stamp == new_ff.stamp) begin
               emit = 1'b1;
               item.slot = 5'(idx_ff);
               if (op_ff == OP_EXISTS) begin
                  item.kind = KIND_EXISTS;
                  item.ok = 1'b1;
               end else begin
                  item.kind = KIND_RELEASED;
                  item.out_stamp = rd_data_ff.stamp;
                  item.out_frame_handle = rd_data_ff.handle;
               end
               if (emit_ok) begin
                  pos_in = idx_ff[IW-1:0];
                  idx_in = idx_ff + CW'(1);
                  state_in = (op_ff == OP_EXISTS) ? ST_FIN : ST_SHFT_RD;
               end
            end else begin
               idx_in = idx_ff + CW'(1);
               state_in = ST_SRCH_RD;
            end
         end
         ST_SHFT_RD: begin
            if (idx_ff == count_ff) begin
               state_in = ST_CONF;
            end else begin
               mem_re = 1'b1;
               state_in = ST_SHFT_EX;
            end
         end
         ST_SHFT_EX: begin
            mem_we = 1'b1;
            mem_waddr = idx_dec[IW-1:0];
            idx_in = idx_ff + CW'(1);
            state_in = ST_SHFT_RD;
         end
         ST_CONF: begin
            emit = 1'b1;
            item.kind = KIND_CONFIRM;
            item.ok = 1'b1;
            item.slot = 5'(pos_ff);
            if (emit_ok) begin
               count_in = count_ff - CW'(1);
               state_in = ST_FIN;
            end
         end
         ST_DROP_RD: begin
            if (idx_ff == count_ff) begin
               count_in = keep_ff;
               idx_in = '0;
               state_in = ST_SEND_RD;
            end else begin
               mem_re = 1'b1;
               state_in = ST_DROP_EX;
            end
         end
         ST_DROP_EX: begin
            if (rd_data_ff.retries > limit_ff) begin
               emit = 1'b1;
               item.kind = KIND_RELEASED;
               item.slot = 5'(keep_ff);
               item.out_stamp = rd_data_ff.stamp;
               item.out_frame_handle = rd_data_ff.handle;
               if (emit_ok) begin
                  idx_in = idx_ff + CW'(1);
                  state_in = ST_DROP_RD;
               end
            end else begin
               // Survivors slide down over the gaps left by dropped entries.
               mem_we = (keep_ff != idx_ff);
               mem_waddr = keep_ff[IW-1:0];
               keep_in = keep_ff + CW'(1);
               idx_in = idx_ff + CW'(1);
               state_in = ST_DROP_RD;
            end
         end
         ST_SEND_RD: begin
            if (idx_ff == count_ff) begin
               state_in = ST_FIN;
            end else begin
               mem_re = 1'b1;
               state_in = ST_SEND_EX;
            end
         end
         ST_SEND_EX: begin
            if (age > interval_ff) begin
               emit = 1'b1;
               item.kind = KIND_RESEND;
               item.slot = 5'(idx_ff);
               item.out_stamp = upd.stamp;
               item.out_dest_addr = upd.dest_addr;
               item.out_dest_port = upd.dest_port;
               item.out_frame_size = upd.size;
               item.out_frame_handle = upd.handle;
               item.out_retries = upd.retries;
               if (emit_ok) begin
                  mem_we = 1'b1;
                  mem_wdata = upd;
                  idx_in = idx_ff + CW'(1);
                  state_in = ST_SEND_RD;
               end
            end else begin
               idx_in = idx_ff + CW'(1);
               state_in = ST_SEND_RD;
            end
         end
         ST_CLR_RD: begin
            if (idx_ff == count_ff) begin
               count_in = '0;
               state_in = ST_FIN;
            end else begin
               mem_re = 1'b1;
               state_in = ST_CLR_EX;
            end
         end
         ST_CLR_EX: begin
            emit = 1'b1;
            item.kind = KIND_RELEASED;
            item.slot = 5'(idx_ff);
            item.out_stamp = rd_data_ff.stamp;
            item.out_frame_handle = rd_data_ff.handle;
            if (emit_ok) begin
               idx_in = idx_ff + CW'(1);
               state_in = ST_CLR_RD;
            end
         end
         ST_FIN: begin
            // The held word is the final one; with none held, report done.
            if (out_free) begin
               out_valid_in = 1'b1;
               if (pend_valid_ff) begin
                  out_in = pend_ff;
               end else begin
                  out_in = '0;
                  out_in.kind = KIND_DONE;
               end
               out_in.last = 1'b1;
               pend_valid_in = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // A new word pushes the held one out, which is then known not to be last.
      if (emit && emit_ok) begin
         pend_in = item;
         pend_valid_in = 1'b1;
         if (pend_valid_ff) begin
            out_in = pend_ff;
            out_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= entry_mem[idx_ff[IW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         limit_ff <= RETRY_LIMIT_RST;
         interval_ff <= RETRY_INTERVAL_RST;
         pend_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         limit_ff <= limit_in;
         interval_ff <= interval_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff <= out_valid_in;
      end
      op_ff <= op_in;
      new_ff <= new_in;
      idx_ff <= idx_in;
      keep_ff <= keep_in;
      pos_ff <= pos_in;
      pend_ff <= pend_in;
      out_ff <= out_in;
   end

   assign rsp.valid = out_valid_ff;
   assign rsp.kind = out_ff.kind;
   assign rsp.ok = out_ff.ok;
   assign rsp.slot = out_ff.slot;
   assign rsp.out_stamp = out_ff.out_stamp;
   assign rsp.out_dest_addr = out_ff.out_dest_addr;
   assign rsp.out_dest_port = out_ff.out_dest_port;
   assign rsp.out_frame_size = out_ff.out_frame_size;
   assign rsp.out_frame_handle = out_ff.out_frame_handle;
   assign rsp.out_retries = out_ff.out_retries;
   assign rsp.last = out_ff.last;

`ifndef SYNTH
   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      req.ready |-> !pend_valid_ff)
      else $error("held result word left over between operations");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(QUEUE_DEPTH))
      else $error("entry count beyond table depth");
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> !req.ready)
      else $error("request taken while an operation is in progress");
`endif

endmodule

// ----- verif/retransmit_queue_engine_tb.sv -----
// Self-checking testbench for the retransmit queue engine: directed and random
// operation words, a table model that predicts every result word, random stalls.
// Depends on rqe_pkg, the rqe_req_if/rqe_rsp_if/rqe_csr_if interfaces and the RTL.
module retransmit_queue_engine_tb;
   import rqe_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH       = QUEUE_DEPTH_DEF;
   localparam int STALL_LIMIT = 20000;
   localparam int SETTLE      = 4 * DEPTH + 10;
   localparam logic [2:0] OP_UNUSED_LO = 3'd5;
   localparam logic [2:0] OP_UNUSED_HI = 3'd7;

   typedef struct packed {
      logic [2:0]  op;
      logic [31:0] stamp;
      logic [31:0] dest_addr;
      logic [15:0] dest_port;
      logic [15:0] frame_size;
      logic [31:0] frame_handle;
      logic [31:0] now;
   } op_word_type;

   logic clock;
   logic reset;

   rqe_req_if req_bus ();
   rqe_rsp_if rsp_bus ();
   rqe_csr_if csr_bus ();

   retransmit_queue_engine u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus),
      .csr   (csr_bus)
   );

   // Table model
   entry_type   tbl_entries [DEPTH];
   int          tbl_count;
   logic [7:0]  cur_retry_limit;
   logic [31:0] cur_retry_interval;

   rsp_type     pending_rsp [$];
   int          error_count;
   bit          quiet;
   int          idle_cycles;
   logic [31:0] tick;
   logic [31:0] stamp_pool [16];

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic rsp_type plain_word(logic [2:0] kind, logic ok, int slot);
      rsp_type r;
      r = '0;
      r.kind = kind;
      r.ok   = ok;
      r.slot = slot[4:0];
      return r;
   endfunction

   function automatic rsp_type entry_word(logic [2:0] kind, int slot, entry_type e);
      rsp_type r;
      r = plain_word(kind, 1'b0, slot);
      r.out_stamp        = e.stamp;
      r.out_frame_handle = e.handle;
      if (kind == KIND_RESEND) begin
         r.out_dest_addr  = e.dest_addr;
         r.out_dest_port  = e.dest_port;
         r.out_frame_size = e.size;
         r.out_retries    = e.retries;
      end
      return r;
   endfunction

   function automatic bit find_stamp(logic [31:0] s, output int pos);
      pos = 0;
      for (int i = 0; i < tbl_count; i++) begin
         if (tbl_entries[i].stamp == s) begin
            pos = i;
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   task automatic predict_results(op_word_type w);
      int first;
      int pos;
      int keep;
      bit hit;
      logic [31:0] elapsed;
      entry_type e;
      first = pending_rsp.size();
      case (w.op)
         OP_ADD: begin
            if (tbl_count >= DEPTH) begin
               pending_rsp.push_back(plain_word(KIND_ADD, 1'b0, 0));
            end else begin
               e.stamp     = w.stamp;
               e.dest_addr = w.dest_addr;
               e.dest_port = w.dest_port;
               e.size      = w.frame_size;
               e.handle    = w.frame_handle;
               e.sent_at   = w.now;
               e.retries   = '0;
               tbl_entries[tbl_count] = e;
               pending_rsp.push_back(plain_word(KIND_ADD, 1'b1, tbl_count));
               tbl_count++;
            end
         end
         OP_EXISTS: begin
            hit = find_stamp(w.stamp, pos);
            pending_rsp.push_back(plain_word(KIND_EXISTS, hit, hit ? pos : 0));
         end
         OP_CONFIRM: begin
            if (find_stamp(w.stamp, pos)) begin
               pending_rsp.push_back(entry_word(KIND_RELEASED, pos, tbl_entries[pos]));
               for (int i = pos + 1; i < tbl_count; i++) tbl_entries[i-1] = tbl_entries[i];
               tbl_count--;
               pending_rsp.push_back(plain_word(KIND_CONFIRM, 1'b1, pos));
            end else begin
               pending_rsp.push_back(plain_word(KIND_CONFIRM, 1'b0, 0));
            end
         end
         OP_PROCESS: begin
            // Drops first, with slots taken after earlier drops have closed up.
            keep = 0;
            for (int i = 0; i < tbl_count; i++) begin
               if (tbl_entries[i].retries > cur_retry_limit) begin
                  pending_rsp.push_back(entry_word(KIND_RELEASED, keep, tbl_entries[i]));
               end else begin
                  tbl_entries[keep] = tbl_entries[i];
                  keep++;
               end
            end
            tbl_count = keep;
            for (int i = 0; i < tbl_count; i++) begin
               elapsed = w.now - tbl_entries[i].sent_at;
               if (elapsed > cur_retry_interval) begin
                  tbl_entries[i].sent_at = w.now;
                  if (tbl_entries[i].retries != RETRIES_MAX)
                     tbl_entries[i].retries = tbl_entries[i].retries + 8'd1;
                  pending_rsp.push_back(entry_word(KIND_RESEND, i, tbl_entries[i]));
               end
            end
         end
         OP_CLEAR: begin
            for (int i = 0; i < tbl_count; i++)
               pending_rsp.push_back(entry_word(KIND_RELEASED, i, tbl_entries[i]));
            tbl_count = 0;
         end
         default: ;
      endcase
      if (pending_rsp.size() == first) pending_rsp.push_back(plain_word(KIND_DONE, 1'b0, 0));
      pending_rsp[pending_rsp.size()-1].last = 1'b1;
   endtask

   // Sender: random gaps before a word unless the run is in its quiet part.
   task automatic send_word(op_word_type w);
      int gap;
      if (!quiet && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 6);
         repeat (gap) begin
            @(negedge clock);
            req_bus.valid = 1'b0;
         end
      end
      @(negedge clock);
      req_bus.op           = w.op;
      req_bus.stamp        = w.stamp;
      req_bus.dest_addr    = w.dest_addr;
      req_bus.dest_port    = w.dest_port;
      req_bus.frame_size   = w.frame_size;
      req_bus.frame_handle = w.frame_handle;
      req_bus.now          = w.now;
      req_bus.valid        = 1'b1;
      do @(posedge clock); while (!req_bus.ready);
      predict_results(w);
      @(negedge clock);
      req_bus.valid = 1'b0;
   endtask

   function automatic op_word_type make_word(logic [2:0] op, logic [31:0] stamp);
      op_word_type w;
      w.op           = op;
      w.stamp        = stamp;
      w.dest_addr    = $urandom;
      w.dest_port    = $urandom;
      w.frame_size   = $urandom;
      w.frame_handle = $urandom;
      w.now          = tick;
      return w;
   endfunction

   task automatic send_op(logic [2:0] op, logic [31:0] stamp);
      send_word(make_word(op, stamp));
   endtask

   task automatic wait_drained();
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [31:0] data);
      wait_drained();
      @(negedge clock);
      csr_bus.index = idx;
      csr_bus.data  = data;
      csr_bus.valid = 1'b1;
      do @(posedge clock); while (!csr_bus.ready);
      if (idx == CSR_RETRY_LIMIT) cur_retry_limit = data[7:0];
      else cur_retry_interval = data;
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   // Result side: random stall bursts, none in the quiet part.
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (reset) begin
            rsp_bus.ready = 1'b0;
         end else if (stall_left > 0) begin
            rsp_bus.ready = 1'b0;
            stall_left--;
         end else if (!quiet && $urandom_range(0, 9) == 0) begin
            rsp_bus.ready = 1'b0;
            stall_left = $urandom_range(0, 5);
         end else begin
            rsp_bus.ready = 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_rsp.size() == 0) begin
            $error("result word with nothing expected: kind %0d", rsp_bus.kind);
            error_count++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_bus.kind !== want.kind) begin
               $error("kind: expected %0d, got %0d", want.kind, rsp_bus.kind);
               error_count++;
            end
            if (rsp_bus.ok !== want.ok) begin
               $error("ok: expected %0d, got %0d", want.ok, rsp_bus.ok);
               error_count++;
            end
            if (rsp_bus.slot !== want.slot) begin
               $error("slot: expected %0d, got %0d", want.slot, rsp_bus.slot);
               error_count++;
            end
            if (rsp_bus.out_stamp !== want.out_stamp) begin
               $error("out_stamp: expected %h, got %h", want.out_stamp, rsp_bus.out_stamp);
               error_count++;
            end
            if (rsp_bus.out_dest_addr !== want.out_dest_addr) begin
               $error("out_dest_addr: expected %h, got %h",
                      want.out_dest_addr, rsp_bus.out_dest_addr);
               error_count++;
            end
            if (rsp_bus.out_dest_port !== want.out_dest_port) begin
               $error("out_dest_port: expected %h, got %h",
                      want.out_dest_port, rsp_bus.out_dest_port);
               error_count++;
            end
            if (rsp_bus.out_frame_size !== want.out_frame_size) begin
               $error("out_frame_size: expected %h, got %h",
                      want.out_frame_size, rsp_bus.out_frame_size);
               error_count++;
            end
            if (rsp_bus.out_frame_handle !== want.out_frame_handle) begin
               $error("out_frame_handle: expected %h, got %h",
                      want.out_frame_handle, rsp_bus.out_frame_handle);
               error_count++;
            end
            if (rsp_bus.out_retries !== want.out_retries) begin
               $error("out_retries: expected %0d, got %0d",
                      want.out_retries, rsp_bus.out_retries);
               error_count++;
            end
            if (rsp_bus.last !== want.last) begin
               $error("last: expected %0d, got %0d", want.last, rsp_bus.last);
               error_count++;
            end
         end
      end
   end

   // Watchdog on cycles in which no word moves on any channel.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (csr_bus.valid && csr_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic test_empty_table();
      op_word_type w;
      send_op(OP_EXISTS, 32'h0);
      send_op(OP_CONFIRM, 32'hFFFF_FFFF);
      send_op(OP_PROCESS, 32'h0);
      send_op(OP_CLEAR, 32'h0);
      for (int op = OP_UNUSED_LO; op <= OP_UNUSED_HI; op++) send_op(op[2:0], $urandom);
      // Field extremes, all zeros then all ones.
      w = '0;
      send_word(w);
      w = '1;
      w.op = OP_ADD;
      send_word(w);
      send_op(OP_EXISTS, 32'hFFFF_FFFF);
      send_op(OP_EXISTS, 32'h0);
      send_op(OP_CONFIRM, 32'h0);
      tick = 32'd1001;
      send_op(OP_PROCESS, 32'h0);
      send_op(OP_CLEAR, 32'h0);
   endtask

   task automatic test_full_table();
      for (int i = 0; i < DEPTH; i++) send_op(OP_ADD, stamp_pool[i % 16]);
      send_op(OP_ADD, 32'h1234_5678);
      send_op(OP_CONFIRM, stamp_pool[3]);
      send_op(OP_EXISTS, stamp_pool[3]);
      send_op(OP_CONFIRM, stamp_pool[0]);
      send_op(OP_CLEAR, 32'h0);
   endtask

   task automatic test_retry_drop();
      write_reg(CSR_RETRY_LIMIT, 32'd0);
      write_reg(CSR_RETRY_INTERVAL, 32'd0);
      for (int i = 0; i < 4; i++) send_op(OP_ADD, stamp_pool[i]);
      tick = tick + 1;
      send_op(OP_PROCESS, 32'h0);
      send_op(OP_PROCESS, 32'h0);
      tick = tick + 1;
      send_op(OP_PROCESS, 32'h0);
      send_op(OP_PROCESS, 32'h0);
      write_reg(CSR_RETRY_INTERVAL, 32'hFFFF_FFFF);
      write_reg(CSR_RETRY_LIMIT, 32'd254);
      send_op(OP_ADD, stamp_pool[5]);
      tick = tick - 1;
      send_op(OP_PROCESS, 32'h0);
      send_op(OP_CLEAR, 32'h0);
   endtask

   task automatic send_random_word();
      int r;
      logic [2:0] op;
      logic [31:0] s;
      r = $urandom_range(0, 99);
      if (r < 38) op = OP_ADD;
      else if (r < 52) op = OP_EXISTS;
      else if (r < 72) op = OP_CONFIRM;
      else if (r < 92) op = OP_PROCESS;
      else if (r < 96) op = OP_CLEAR;
      else op = 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
      s = ($urandom_range(0, 7) == 0) ? $urandom : stamp_pool[$urandom_range(0, 15)];
      // Ticks mostly move forward slowly so resends and drops both happen.
      if ($urandom_range(0, 19) == 0) tick = $urandom;
      else tick = tick + $urandom_range(0, 700);
      send_op(op, s);
   endtask

   task automatic test_random_phases(int phases, int per_phase);
      for (int p = 0; p < phases; p++) begin
         case ($urandom_range(0, 4))
            0: write_reg(CSR_RETRY_LIMIT, 32'd0);
            1: write_reg(CSR_RETRY_LIMIT, 32'd254);
            default: write_reg(CSR_RETRY_LIMIT, $urandom_range(0, 6));
         endcase
         case ($urandom_range(0, 4))
            0: write_reg(CSR_RETRY_INTERVAL, 32'd0);
            1: write_reg(CSR_RETRY_INTERVAL, 32'hFFFF_FFFF);
            default: write_reg(CSR_RETRY_INTERVAL, $urandom_range(100, 1500));
         endcase
         for (int i = 0; i < per_phase; i++) send_random_word();
      end
   endtask

   task automatic test_drain_pause();
      for (int i = 0; i < 6; i++) send_op(OP_ADD, stamp_pool[i]);
      while (pending_rsp.size() != 0) @(posedge clock);
      tick = tick + 32'd5000;
      send_op(OP_PROCESS, 32'h0);
      send_op(OP_CLEAR, 32'h0);
   endtask

   initial begin
      reset = 1'b1;
      quiet = 1'b0;
      error_count = 0;
      idle_cycles = 0;
      tick = '0;
      req_bus.valid = 1'b0;
      req_bus.op = OP_ADD;
      req_bus.stamp = '0;
      req_bus.dest_addr = '0;
      req_bus.dest_port = '0;
      req_bus.frame_size = '0;
      req_bus.frame_handle = '0;
      req_bus.now = '0;
      csr_bus.valid = 1'b0;
      csr_bus.index = CSR_RETRY_LIMIT;
      csr_bus.data = '0;
      tbl_count = 0;
      cur_retry_limit = RETRY_LIMIT_RST;
      cur_retry_interval = RETRY_INTERVAL_RST;
      stamp_pool[0] = 32'h0;
      stamp_pool[1] = 32'hFFFF_FFFF;
      for (int i = 2; i < 16; i++) stamp_pool[i] = $urandom;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_empty_table();
      test_full_table();
      test_retry_drop();
      test_drain_pause();
      test_random_phases(6, 55);
      quiet = 1'b1;
      test_random_phases(1, 60);

      @(negedge clock);
      req_bus.valid = 1'b0;
      wait_drained();
      if (error_count == 0 && pending_rsp.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
